@@ sv/lesf_pkg.sv @@
// shared types and constants of the largest empty square finder
// no dependencies; imported by every module of the block
package lesf_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned COLCNT_W   = 11;
  localparam int unsigned ROWCNT_W   = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned OUT_ROW_W  = 12;
  localparam int unsigned OUT_COL_W  = 10;
  // wide enough for any clamped count up to 65536
  localparam int unsigned CNT_W      = 17;

  localparam logic [SIZE_W-1:0] SIZE_SAT = '1;

  localparam logic [COLCNT_W-1:0] COLCNT_RESET  = 11'd1024;
  localparam logic [ROWCNT_W-1:0] ROWCNT_RESET  = 13'd4096;
  localparam logic [CHAR_W-1:0]   OBSTACLE_RESET = 8'd111;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMN_COUNT  = 2'd0,
    REG_ROW_COUNT     = 2'd1,
    REG_OBSTACLE_CHAR = 2'd2
  } lesf_reg_idx_t;

  typedef struct packed {
    logic row_zero;
    logic col_zero;
    logic last_col;
    logic last_grid;
  } lesf_pos_flags_t;

endpackage

@@ sv/largest_empty_square_finder_core.sv @@
// Largest empty square finder: top level with configuration, size pipeline and result register
// Depends on lesf_pkg, lesf_scan_ctrl and lesf_line_buf.
//
// Grid cells enter on the input channel (in_valid, in_stall, cell_char) one per
// transaction in row-major order. Each cell gets the side of the largest empty
// square ending there; the largest one, first in scan order on ties, is reported
// on the output channel (out_valid, out_stall, square_size, corner_row,
// corner_col) once per grid, after its last cell.
// The pipeline has two stages: the first steps the scan counters and reads the
// line buffer, the second forms the size, writes it back and updates the best.
// The result register loads as the last cell of a grid leaves the second stage.
// Throughput is one cell per clock while in_stall is low, set by the line buffer's
// single read port and single write port, which are both used on every cell.
// A stalled result sits in the output register while cells keep streaming;
// the input stalls only when the next grid end arrives with that register full.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) are registered and must be
// made while the block is idle; the block itself does not enforce it. Reset clears
// the counters, the best square and the configuration to 1024 columns, 4096 rows
// and obstacle code 111; the line buffer is not cleared, as first-row reads go unused.
module largest_empty_square_finder_core #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lesf_pkg::CHAR_W-1:0]     cell_char,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lesf_pkg::SIZE_W-1:0]     square_size,
  output logic [lesf_pkg::OUT_ROW_W-1:0]  corner_row,
  output logic [lesf_pkg::OUT_COL_W-1:0]  corner_col,
  input  logic                            cfg_wr_en,
  input  logic [lesf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lesf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lesf_pkg::*;

  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // configuration
  logic [COLCNT_W-1:0] column_count;
  logic [ROWCNT_W-1:0] row_count;
  logic [CHAR_W-1:0]   obstacle_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= COLCNT_RESET;
      row_count     <= ROWCNT_RESET;
      obstacle_char <= OBSTACLE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COLUMN_COUNT:  column_count  <= cfg_data[COLCNT_W-1:0];
        REG_ROW_COUNT:     row_count     <= cfg_data[ROWCNT_W-1:0];
        REG_OBSTACLE_CHAR: obstacle_char <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic in_accept;
  logic s1_valid;
  logic s1_done;
  logic s1_free;
  lesf_pos_flags_t s1_flags;

  assign s1_done   = !s1_flags.last_grid || !out_valid || !out_stall;
  assign s1_free   = !s1_valid || s1_done;
  assign in_stall  = !s1_free;
  assign in_accept = in_valid && s1_free;

  // stage 0: scan position and line buffer read
  logic [CW-1:0]   scan_col;
  logic [RW-1:0]   scan_row;
  lesf_pos_flags_t scan_flags;

  lesf_scan_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CW       (CW),
    .RW       (RW)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (in_accept),
    .column_count (column_count),
    .row_count    (row_count),
    .col          (scan_col),
    .row          (scan_row),
    .flags        (scan_flags)
  );

  logic [SIZE_W-1:0] up_size;
  logic [SIZE_W-1:0] cell_size;
  logic              s1_wr;
  logic [CW-1:0]     s1_col;
  logic [RW-1:0]     s1_row;
  logic              s1_obst;

  assign s1_wr = s1_valid && s1_done;

  lesf_line_buf #(
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_line (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_addr (scan_col),
    .rd_data (up_size),
    .wr_en   (s1_wr),
    .wr_addr (s1_col),
    .wr_data (cell_size)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col   <= scan_col;
      s1_row   <= scan_row;
      s1_flags <= scan_flags;
      s1_obst  <= (cell_char == obstacle_char);
    end
  end

  // stage 1: size of the square ending at this cell
  logic [SIZE_W-1:0] left_size;
  logic [SIZE_W-1:0] diagonal_size;
  logic [SIZE_W-1:0] min_size;

  always_comb begin
    min_size = up_size;
    if (left_size < min_size) begin
      min_size = left_size;
    end
    if (diagonal_size < min_size) begin
      min_size = diagonal_size;
    end
    if (s1_obst) begin
      cell_size = '0;
    end else if (s1_flags.row_zero || s1_flags.col_zero) begin
      cell_size = SIZE_W'(1);
    end else if (min_size == SIZE_SAT) begin
      cell_size = SIZE_SAT;
    end else begin
      cell_size = min_size + SIZE_W'(1);
    end
  end

  // best square so far, first in scan order wins
  logic [SIZE_W-1:0] best_size;
  logic [RW-1:0]     best_row;
  logic [CW-1:0]     best_col;
  logic              better;
  logic [SIZE_W-1:0] best_size_next;
  logic [RW-1:0]     best_row_next;
  logic [CW-1:0]     best_col_next;

  assign better         = cell_size > best_size;
  assign best_size_next = better ? cell_size : best_size;
  assign best_row_next  = better ? s1_row : best_row;
  assign best_col_next  = better ? s1_col : best_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_size     <= '0;
      diagonal_size <= '0;
      best_size     <= '0;
      best_row      <= '0;
      best_col      <= '0;
    end else if (s1_wr) begin
      if (s1_flags.last_col) begin
        left_size     <= '0;
        diagonal_size <= '0;
      end else begin
        left_size     <= cell_size;
        diagonal_size <= up_size;
      end
      if (s1_flags.last_grid) begin
        best_size <= '0;
        best_row  <= '0;
        best_col  <= '0;
      end else begin
        best_size <= best_size_next;
        best_row  <= best_row_next;
        best_col  <= best_col_next;
      end
    end
  end

  // result register
  logic result_load;

  assign result_load = s1_wr && s1_flags.last_grid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      square_size <= best_size_next;
      corner_row  <= OUT_ROW_W'(best_row_next);
      corner_col  <= OUT_COL_W'(best_col_next);
    end
  end

endmodule

@@ sv/lesf_line_buf.sv @@
// line buffer holding the previous row's square sizes, one read and one write port
// read data registered, same-cycle write to the read address is forwarded; uses lesf_pkg
module lesf_line_buf #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [lesf_pkg::SIZE_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [lesf_pkg::SIZE_W-1:0] wr_data
);
  import lesf_pkg::*;

  logic [SIZE_W-1:0] mem [DEPTH];
  logic [SIZE_W-1:0] mem_q;
  logic [SIZE_W-1:0] fwd_q;
  logic              hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      fwd_q <= wr_data;
    end
  end

  // the read sees the new data when the write lands on the same entry
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (rd_en) begin
      hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = hit ? fwd_q : mem_q;

endmodule

@@ sv/lesf_scan_ctrl.sv @@
// row and column counters of the raster scan, with end-of-row and end-of-grid flags
// counts are clamped to the range from one to the parameter maxima; uses lesf_pkg
module lesf_scan_ctrl #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 4096,
  parameter int unsigned CW       = 10,
  parameter int unsigned RW       = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [lesf_pkg::COLCNT_W-1:0] column_count,
  input  logic [lesf_pkg::ROWCNT_W-1:0] row_count,
  output logic [CW-1:0]                 col,
  output logic [RW-1:0]                 row,
  output lesf_pkg::lesf_pos_flags_t     flags
);
  import lesf_pkg::*;

  logic [CNT_W-1:0] cols_eff;
  logic [CNT_W-1:0] rows_eff;
  logic [CNT_W-1:0] cols_raw;
  logic [CNT_W-1:0] rows_raw;

  assign cols_raw = CNT_W'(column_count);
  assign rows_raw = CNT_W'(row_count);

  always_comb begin
    if (cols_raw == '0) begin
      cols_eff = CNT_W'(1);
    end else if (cols_raw > CNT_W'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = cols_raw;
    end
    if (rows_raw == '0) begin
      rows_eff = CNT_W'(1);
    end else if (rows_raw > CNT_W'(MAX_ROWS)) begin
      rows_eff = CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_raw;
    end
  end

  always_comb begin
    flags.row_zero  = (row == '0);
    flags.col_zero  = (col == '0);
    flags.last_col  = (CNT_W'(col) + CNT_W'(1)) >= cols_eff;
    flags.last_grid = flags.last_col && ((CNT_W'(row) + CNT_W'(1)) >= rows_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (step) begin
      if (flags.last_grid) begin
        col <= '0;
        row <= '0;
      end else if (flags.last_col) begin
        col <= '0;
        row <= row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

endmodule

@@ sv/lesf_checker.sv @@
// port-level checks for the largest empty square finder
// bound to largest_empty_square_finder_core; uses lesf_pkg
module lesf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [lesf_pkg::SIZE_W-1:0]    square_size,
  input logic [lesf_pkg::OUT_ROW_W-1:0] corner_row,
  input logic [lesf_pkg::OUT_COL_W-1:0] corner_col
);
  import lesf_pkg::*;

  // a held result stays valid and its size stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(square_size))
    else $error("result dropped or changed while stalled");

  // input backpressure only comes from a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // an empty result points at the origin
  a_empty_origin: assert property (@(posedge clk) disable iff (rst)
    out_valid && (square_size == '0) |-> (corner_row == '0) && (corner_col == '0))
    else $error("empty result with nonzero corner");

  // the square fits above and left of its corner
  a_square_fits: assert property (@(posedge clk) disable iff (rst)
    out_valid && (square_size != '0) |->
      (13'(corner_col) + 13'd1 >= 13'(square_size)) &&
      (13'(corner_row) + 13'd1 >= 13'(square_size)))
    else $error("square extends past the grid origin");

endmodule

bind largest_empty_square_finder_core lesf_checker u_lesf_checker (.*);
